FILE: sv/sdec_pkg.sv
// shared types and constants for the signed integer to decimal text unit
// used by sdec_ctrl, sdec_dpath and signed_int_to_decimal_ascii_unit; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sdec_pkg;

    localparam int VALUE_BITS = 32;

    // number of decimal digits needed for the largest magnitude, 2^(VALUE_BITS-1)
    function automatic int max_digits();
        longint unsigned m;
        int n;
        begin
            m = longint'(1) << (VALUE_BITS - 1);
            n = 0;
            while (m != 0) begin
                m = m / 10;
                n = n + 1;
            end
            return n;
        end
    endfunction

    localparam int NUM_DIGITS = max_digits();
    localparam int BCD_BITS   = 4 * NUM_DIGITS;
    localparam int IDX_BITS   = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam int CNT_BITS   = $clog2(VALUE_BITS);
    localparam int CHAR_BITS  = 7;

    localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 7'd48;
    localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 7'd45;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_FIND,
        S_SIGN,
        S_DIGIT
    } t_sdec_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic shift;
        logic locate;
        logic emit_sign;
        logic emit_digit;
    } t_sdec_cmd;

    // datapath to controller
    typedef struct packed {
        logic shift_last;
        logic neg;
        logic idx_zero;
    } t_sdec_sts;

endpackage

`default_nettype wire

FILE: sv/sdec_ctrl.sv
// controller state machine: load, binary to bcd shifts, leading digit search, emission
// depends on sdec_pkg
`timescale 1ns / 1ps
`default_nettype none

module sdec_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  sdec_pkg::t_sdec_sts  i_sts,
    output sdec_pkg::t_sdec_cmd  o_cmd,
    output logic                 o_busy
);
    import sdec_pkg::*;

    t_sdec_state r_state;
    t_sdec_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CONV;
                end
            end
            S_CONV: begin
                o_cmd.shift = 1'b1;
                if (i_sts.shift_last) begin
                    n_state = S_FIND;
                end
            end
            S_FIND: begin
                o_cmd.locate = 1'b1;
                n_state      = i_sts.neg ? S_SIGN : S_DIGIT;
            end
            S_SIGN: begin
                o_cmd.emit_sign = 1'b1;
                n_state         = S_DIGIT;
            end
            S_DIGIT: begin
                o_cmd.emit_digit = 1'b1;
                if (i_sts.idx_zero) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: sv/sdec_dpath.sv
// datapath: magnitude, shift-add-3 bcd conversion, digit index and output register
// depends on sdec_pkg
`timescale 1ns / 1ps
`default_nettype none

module sdec_dpath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic signed [sdec_pkg::VALUE_BITS-1:0] i_value,
    input  sdec_pkg::t_sdec_cmd                 i_cmd,
    output sdec_pkg::t_sdec_sts                 o_sts,
    output logic                                o_char_valid,
    output logic [sdec_pkg::CHAR_BITS-1:0]      o_char_code,
    output logic                                o_last_char
);
    import sdec_pkg::*;

    logic                  r_neg;
    logic [VALUE_BITS-1:0] r_bin;
    logic [BCD_BITS-1:0]   r_bcd;
    logic [CNT_BITS-1:0]   r_cnt;
    logic [IDX_BITS-1:0]   r_idx;
    logic                  r_char_valid;
    logic [CHAR_BITS-1:0]  r_char_code;
    logic                  r_last_char;

    logic [VALUE_BITS-1:0] n_mag;
    logic [BCD_BITS-1:0]   n_adj;
    logic [IDX_BITS-1:0]   n_lead;
    logic [3:0]            n_digit;

    // two's complement magnitude, unsigned so the most negative value is exact
    assign n_mag = i_value[VALUE_BITS-1] ? (~unsigned'(i_value) + 1'b1) : unsigned'(i_value);

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        n_adj = r_bcd;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (r_bcd[4*i +: 4] >= 4'd5) begin
                n_adj[4*i +: 4] = r_bcd[4*i +: 4] + 4'd3;
            end
        end
    end

    // highest nonzero digit, digit 0 when the value is zero
    always_comb begin
        n_lead = '0;
        for (int i = 1; i < NUM_DIGITS; i++) begin
            if (r_bcd[4*i +: 4] != 4'd0) begin
                n_lead = IDX_BITS'(i);
            end
        end
    end

    assign n_digit = r_bcd[4*r_idx +: 4];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg <= i_value[VALUE_BITS-1];
            r_bin <= n_mag;
            r_bcd <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.shift) begin
            r_bcd <= {n_adj[BCD_BITS-2:0], r_bin[VALUE_BITS-1]};
            r_bin <= {r_bin[VALUE_BITS-2:0], 1'b0};
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.locate) begin
            r_idx <= n_lead;
        end
        if (i_cmd.emit_digit) begin
            r_idx <= r_idx - 1'b1;
        end
        r_char_code <= i_cmd.emit_sign ? CHAR_MINUS : (CHAR_ZERO + {3'b000, n_digit});
        r_last_char <= i_cmd.emit_digit && (r_idx == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_valid <= 1'b0;
        end else begin
            r_char_valid <= i_cmd.emit_sign || i_cmd.emit_digit;
        end
    end

    assign o_sts.shift_last = (r_cnt == CNT_BITS'(VALUE_BITS - 1));
    assign o_sts.neg        = r_neg;
    assign o_sts.idx_zero   = (r_idx == '0);

    assign o_char_valid = r_char_valid;
    assign o_char_code  = r_char_code;
    assign o_last_char  = r_last_char;

endmodule

`default_nettype wire

FILE: sv/signed_int_to_decimal_ascii_unit.sv
// top level of the signed integer to decimal ascii text unit
// depends on sdec_pkg, sdec_ctrl and sdec_dpath
//
// the first character reaches the ports after the start transfer passes through
// (32 shift-add-3 steps, 1 leading digit search, 1 output register)
// a value gives 1 to 11 characters, one character a cycle; start is taken only while idle
// busy covers the shift-add-3 loop over the 32 magnitude bits and the emission,
// but not the last character on the ports; reset (synchronous, active low) idles the
// controller and clears the strobe; the receiver cannot stall: each character is on the ports for exactly one cycle
`timescale 1ns / 1ps
`default_nettype none

module signed_int_to_decimal_ascii_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic signed [sdec_pkg::VALUE_BITS-1:0] i_value,
    output logic                                   o_busy,
    output logic                                   o_char_valid,
    output logic [sdec_pkg::CHAR_BITS-1:0]         o_char_code,
    output logic                                   o_last_char
);
    import sdec_pkg::*;

    // command and status between the controller and the datapath
    t_sdec_cmd w_cmd;
    t_sdec_sts w_sts;

    // sequencer: idle, convert, find leading digit, sign, digits
    sdec_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (o_busy)
    );

    // magnitude, bcd register, digit pointer and registered character output
    sdec_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_value      (i_value),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .o_char_valid (o_char_valid),
        .o_char_code  (o_char_code),
        .o_last_char  (o_last_char)
    );

    // a transfer always starts a conversion that keeps the unit busy
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("start transfer did not make the unit busy");

    // the last character of a value is followed by a gap before the next text
    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_char_valid && o_last_char) |=> !o_char_valid)
        else $error("character strobe right after the last character");

    // only a minus sign or a decimal digit is ever emitted
    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_char_valid |-> ((o_char_code == CHAR_MINUS) ||
                          ((o_char_code >= CHAR_ZERO) && (o_char_code <= CHAR_ZERO + 7'd9))))
        else $error("character code outside the minus sign and digits");

    // the sign is never the last character
    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_char_valid && (o_char_code == CHAR_MINUS)) |-> !o_last_char)
        else $error("minus sign marked as the last character");

    // characters only come out while a conversion is under way or just finished
    a_char_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_char_valid && !o_last_char) |-> o_busy)
        else $error("character strobe while idle");

endmodule

`default_nettype wire
